// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the scoreboard RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DRBTS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scoreboard assertion failed");

// Next-cycle implication, disabled during reset.
`define DRBTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scoreboard assertion failed");

`endif

// ----- rtl/drbts_pkg.sv -----
// Types, codes and constants of the DRAM row-buffer timing scoreboard.
package drbts_pkg;

    localparam int ADDRESS_RANGE = 1048576;
    localparam int ROW_SIZE      = 1024;
    localparam int ADDR_W        = 20;
    localparam int ROW_LSB       = $clog2(ROW_SIZE);
    localparam int ROW_W         = $clog2(ADDRESS_RANGE) - ROW_LSB;
    localparam int DELAY_W       = 10;
    localparam int ROW_LEFT_W    = DELAY_W + 1;
    localparam int CYC_W         = 12;
    localparam int CNT_W         = 32;
    localparam int REG_W         = 5;
    localparam int FUNC_W        = 3;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 1;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADDI  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_STORE = 3'd3;

    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HIT      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CONFLICT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_DELAY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_DELAY = 1'd1;

    localparam logic [DELAY_W-1:0] ROW_DELAY_RST = 10'd10;
    localparam logic [DELAY_W-1:0] COL_DELAY_RST = 10'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [REG_W-1:0]  dest_reg;
        logic [REG_W-1:0]  src_a_reg;
        logic [REG_W-1:0]  src_b_reg;
        logic [ADDR_W-1:0] mem_address;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0]      open_row;
        logic                  open_row_valid;
        logic [ROW_LEFT_W-1:0] row_left;
        logic [DELAY_W-1:0]    col_left;
        logic                  pending_is_store;
        logic [REG_W-1:0]      pending_reg;
        logic [CNT_W-1:0]      cycle_count;
        logic [CNT_W-1:0]      update_count;
    } t_state;

    typedef struct packed {
        logic [CYC_W-1:0]  stall_cycles;
        logic [CNT_W-1:0]  issue_cycle;
        logic [KIND_W-1:0] access_kind;
        logic [CYC_W-1:0]  access_cycles;
        logic [CNT_W-1:0]  row_updates;
    } t_result;

endpackage

// ----- rtl/dram_row_buffer_timing_scoreboard_core.sv -----
// Top level of the DRAM open-row timing scoreboard: input register, step logic, result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------------
//  in      | in        | i_in_valid / o_in_stall | func, dest_reg, src_a_reg, src_b_reg, mem_address
//  out     | out       | o_out_valid / i_out_stall | stall_cycles, issue_cycle, access_kind,
//          |           |                        | access_cycles, row_updates
//  cfg     | in        | i_cfg_we               | i_cfg_index, i_cfg_data
//
// One instruction per cycle sustained unless the output stalls.
// The scoreboard state updates in the cycle an item moves from the input register to the
// result register, so consecutive items chain through that single register set.
// Synchronous active-low reset clears the scoreboard state and the valids, and reloads the
// default row and column delays.
// A stalled output holds its result and the input register, and stalls the input only when full.
module dram_row_buffer_timing_scoreboard_core
    import drbts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DELAY_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [REG_W-1:0]     i_dest_reg,
    input  logic [REG_W-1:0]     i_src_a_reg,
    input  logic [REG_W-1:0]     i_src_b_reg,
    input  logic [ADDR_W-1:0]    i_mem_address,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CYC_W-1:0]     o_stall_cycles,
    output logic [CNT_W-1:0]     o_issue_cycle,
    output logic [KIND_W-1:0]    o_access_kind,
    output logic [CYC_W-1:0]     o_access_cycles,
    output logic [CNT_W-1:0]     o_row_updates
);

`include "assert_macros.svh"

    logic [DELAY_W-1:0] r_row_delay;
    logic [DELAY_W-1:0] r_col_delay;
    t_item              r_in;
    logic               r_in_valid;
    t_state             r_state;
    t_state             n_state;
    t_result            r_out;
    t_result            n_out;
    logic               r_out_valid;
    logic               w_adv;
    logic               w_in_take;

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_delay <= ROW_DELAY_RST;
            r_col_delay <= COL_DELAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_DELAY: r_row_delay <= i_cfg_data;
                CFG_COL_DELAY: r_col_delay <= i_cfg_data;
                default:       r_col_delay <= r_col_delay;
            endcase
        end
    end

    drbts_step u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .i_row_delay (r_row_delay),
        .i_col_delay (r_col_delay),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            // Advance: commit the scoreboard update together with its result.
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.func        <= i_func;
            r_in.dest_reg    <= i_dest_reg;
            r_in.src_a_reg   <= i_src_a_reg;
            r_in.src_b_reg   <= i_src_b_reg;
            r_in.mem_address <= i_mem_address;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stall_cycles  = r_out.stall_cycles;
    assign o_issue_cycle   = r_out.issue_cycle;
    assign o_access_kind   = r_out.access_kind;
    assign o_access_cycles = r_out.access_cycles;
    assign o_row_updates   = r_out.row_updates;

    `DRBTS_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    `DRBTS_ASSERT_NOW(a_no_access_no_cost, i_clk, i_rst_n,
        r_out_valid && (r_out.access_kind == KIND_NONE), r_out.access_cycles == '0)
    `DRBTS_ASSERT_NOW(a_no_row_no_delay, i_clk, i_rst_n,
        !r_state.open_row_valid, (r_state.row_left == '0) && (r_state.col_left == '0))
    `DRBTS_ASSERT_NEXT(a_non_mem_keeps_updates, i_clk, i_rst_n,
        w_adv && (r_in.func != FUNC_LOAD) && (r_in.func != FUNC_STORE),
        $stable(r_state.update_count))
    `DRBTS_ASSERT_NEXT(a_stall_drains, i_clk, i_rst_n,
        w_adv && (n_out.stall_cycles != '0) && (n_out.access_kind == KIND_NONE),
        (r_state.row_left == '0) && (r_state.col_left == '0))

endmodule

// ----- rtl/drbts_step.sv -----
// Next-state and result logic for one instruction against the scoreboard state.
module drbts_step
    import drbts_pkg::*;
(
    input  t_state             i_state,
    input  t_item              i_item,
    input  logic [DELAY_W-1:0] i_row_delay,
    input  logic [DELAY_W-1:0] i_col_delay,
    output t_state             o_state,
    output t_result            o_result
);

    always_comb begin
        logic [CYC_W-1:0]      spare;
        logic                  is_add;
        logic                  is_addi;
        logic                  is_mem;
        logic                  dep;
        logic [CYC_W-1:0]      stall;
        logic [ROW_W-1:0]      row;
        logic [ROW_LEFT_W-1:0] r;
        logic                  counts;
        logic [KIND_W-1:0]     kind;

        o_state = i_state;
        spare   = CYC_W'(i_state.row_left) + CYC_W'(i_state.col_left);
        is_add  = (i_item.func == FUNC_ADD);
        is_addi = (i_item.func == FUNC_ADDI);
        is_mem  = (i_item.func == FUNC_LOAD) || (i_item.func == FUNC_STORE);

        // A pending store opening its row stalls add/addi only if they write its register.
        if (i_state.pending_is_store && (i_state.row_left != '0)) begin
            dep = (is_add || is_addi) ? (i_state.pending_reg == i_item.dest_reg) : 1'b1;
        end else if (is_add) begin
            dep = (i_state.pending_reg == i_item.dest_reg) ||
                  (i_state.pending_reg == i_item.src_a_reg) ||
                  (i_state.pending_reg == i_item.src_b_reg);
        end else if (is_addi) begin
            dep = (i_state.pending_reg == i_item.dest_reg) ||
                  (i_state.pending_reg == i_item.src_a_reg);
        end else begin
            dep = 1'b1;
        end

        stall = '0;
        if (spare != '0) begin
            priority if (dep) begin
                stall            = spare;
                o_state.row_left = '0;
                o_state.col_left = '0;
            end else if (i_state.row_left != '0) begin
                o_state.row_left = i_state.row_left - 1'b1;
            end else begin
                o_state.col_left = i_state.col_left - 1'b1;
            end
        end
        o_state.cycle_count = i_state.cycle_count + CNT_W'(stall) + CNT_W'(1);

        // Row index from the address, wrapped into the address range.
        row    = ROW_W'((i_item.mem_address & ADDR_W'(ADDRESS_RANGE - 1)) >> ROW_LSB);
        kind   = KIND_NONE;
        r      = '0;
        counts = 1'b0;
        if (is_mem) begin
            priority if (!i_state.open_row_valid) begin
                kind   = KIND_FIRST;
                r      = ROW_LEFT_W'(i_row_delay);
                counts = 1'b1;
            end else if (row == i_state.open_row) begin
                kind   = KIND_HIT;
            end else begin
                kind   = KIND_CONFLICT;
                r      = {i_row_delay, 1'b0};
                counts = 1'b1;
            end
            o_state.open_row         = row;
            o_state.open_row_valid   = 1'b1;
            o_state.row_left         = r;
            o_state.col_left         = i_col_delay;
            o_state.pending_is_store = (i_item.func == FUNC_STORE);
            o_state.pending_reg      = i_item.dest_reg;
            if (counts && (i_state.update_count != '1)) begin
                o_state.update_count = i_state.update_count + 1'b1;
            end
        end

        o_result.stall_cycles  = stall;
        o_result.issue_cycle   = o_state.cycle_count;
        o_result.access_kind   = kind;
        o_result.access_cycles = is_mem ? (CYC_W'(r) + CYC_W'(i_col_delay)) : '0;
        o_result.row_updates   = o_state.update_count;
    end

endmodule

// ----- bench/drbts_result_checker.sv -----
// Checker for the DRAM row-buffer timing scoreboard: predicts each result and compares it.
module drbts_result_checker
    import drbts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DELAY_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [REG_W-1:0]     i_dest_reg,
    input  logic [REG_W-1:0]     i_src_a_reg,
    input  logic [REG_W-1:0]     i_src_b_reg,
    input  logic [ADDR_W-1:0]    i_mem_address,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [CYC_W-1:0]     i_stall_cycles,
    input  logic [CNT_W-1:0]     i_issue_cycle,
    input  logic [KIND_W-1:0]    i_access_kind,
    input  logic [CYC_W-1:0]     i_access_cycles,
    input  logic [CNT_W-1:0]     i_row_updates,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_conflicts,
    output int                   o_stalled
);

    t_state             timing;
    logic [DELAY_W-1:0] row_delay;
    logic [DELAY_W-1:0] col_delay;
    t_result            timing_q[$];
    t_item              instr;
    t_result            predicted;
    t_result            oldest;

    function automatic logic waits_on_access(input t_item it);
        logic is_add;
        logic is_addi;
        is_add  = (it.func == FUNC_ADD);
        is_addi = (it.func == FUNC_ADDI);
        // A store still writing back its row blocks an add or addi only when it writes its data register.
        if (timing.pending_is_store && timing.row_left != '0) begin
            if (is_add || is_addi) begin
                return timing.pending_reg == it.dest_reg;
            end
            return 1'b1;
        end
        if (is_add) begin
            return timing.pending_reg == it.dest_reg || timing.pending_reg == it.src_a_reg
                || timing.pending_reg == it.src_b_reg;
        end
        if (is_addi) begin
            return timing.pending_reg == it.dest_reg || timing.pending_reg == it.src_a_reg;
        end
        return 1'b1;
    endfunction

    function automatic t_result price_instruction(input t_item it);
        t_result               res;
        logic [CYC_W-1:0]      spare;
        logic [ROW_W-1:0]      row;
        logic [ROW_LEFT_W-1:0] row_cost;
        logic                  new_row;
        res   = '0;
        spare = CYC_W'(timing.row_left) + CYC_W'(timing.col_left);
        if (spare != '0) begin
            if (waits_on_access(it)) begin
                res.stall_cycles   = spare;
                timing.cycle_count = timing.cycle_count + CNT_W'(spare);
                timing.row_left    = '0;
                timing.col_left    = '0;
            end else if (timing.row_left != '0) begin
                timing.row_left = timing.row_left - 1'b1;
            end else begin
                timing.col_left = timing.col_left - 1'b1;
            end
        end
        timing.cycle_count = timing.cycle_count + 1'b1;
        res.access_kind = KIND_NONE;
        if (it.func == FUNC_LOAD || it.func == FUNC_STORE) begin
            row     = ROW_W'((int'(it.mem_address) % ADDRESS_RANGE) / ROW_SIZE);
            new_row = 1'b1;
            if (!timing.open_row_valid) begin
                res.access_kind = KIND_FIRST;
                row_cost        = ROW_LEFT_W'(row_delay);
            end else if (row == timing.open_row) begin
                res.access_kind = KIND_HIT;
                row_cost        = '0;
                new_row         = 1'b0;
            end else begin
                // write back the old row, then open the new one
                res.access_kind = KIND_CONFLICT;
                row_cost        = {row_delay, 1'b0};
            end
            timing.open_row       = row;
            timing.open_row_valid = 1'b1;
            timing.row_left       = row_cost;
            timing.col_left       = col_delay;
            res.access_cycles     = CYC_W'(row_cost) + CYC_W'(col_delay);
            if (new_row && timing.update_count != '1) begin
                timing.update_count = timing.update_count + 1'b1;
            end
            timing.pending_is_store = (it.func == FUNC_STORE);
            timing.pending_reg      = it.dest_reg;
        end
        res.issue_cycle = timing.cycle_count;
        res.row_updates = timing.update_count;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("result %0d: %s expected %0d, got %0d", o_checked, what, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timing    = '0;
            row_delay = ROW_DELAY_RST;
            col_delay = COL_DELAY_RST;
            timing_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_DELAY: row_delay = i_cfg_data;
                    CFG_COL_DELAY: col_delay = i_cfg_data;
                    default: ;
                endcase
            end
            // compare first: a result can never belong to the instruction taken at this edge
            if (i_out_valid && !i_out_stall) begin
                if (timing_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("result %0d arrived with no instruction outstanding", o_checked);
                    end
                end else begin
                    oldest = timing_q.pop_front();
                    check_field("stall_cycles", CNT_W'(oldest.stall_cycles),
                                CNT_W'(i_stall_cycles));
                    check_field("issue_cycle", oldest.issue_cycle, i_issue_cycle);
                    check_field("access_kind", CNT_W'(oldest.access_kind), CNT_W'(i_access_kind));
                    check_field("access_cycles", CNT_W'(oldest.access_cycles),
                                CNT_W'(i_access_cycles));
                    check_field("row_updates", oldest.row_updates, i_row_updates);
                end
                o_checked++;
            end
            if (i_in_valid && !i_in_stall) begin
                instr.func        = i_func;
                instr.dest_reg    = i_dest_reg;
                instr.src_a_reg   = i_src_a_reg;
                instr.src_b_reg   = i_src_b_reg;
                instr.mem_address = i_mem_address;
                predicted = price_instruction(instr);
                if (predicted.access_kind == KIND_CONFLICT) begin
                    o_conflicts++;
                end
                if (predicted.stall_cycles != '0) begin
                    o_stalled++;
                end
                timing_q = {timing_q, predicted};
            end
        end
        o_pending = timing_q.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the DRAM row-buffer timing scoreboard: stimulus, flow control and verdict.
module tb_top
    import drbts_pkg::*;
();

    localparam logic [FUNC_W-1:0] FUNC_OTHER    = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_UNDEF_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNDEF_HI = 3'd7;

    localparam int N_PHASES        = 7;
    localparam int PHASE_ITEMS     = 245;
    localparam int QUIET_PHASE     = 4;
    localparam int RANDOM_PHASE    = 5;
    localparam int HOLD_OFF_AT     = 600;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DRAIN_CYCLES    = 8;
    localparam int IDLE_LIMIT      = 1000;

    localparam logic [DELAY_W-1:0] ROW_SET [N_PHASES] =
        '{10'd0, 10'h3FF, 10'd0, 10'h3FF, 10'd10, 10'd0, 10'd1};
    localparam logic [DELAY_W-1:0] COL_SET [N_PHASES] =
        '{10'd0, 10'h3FF, 10'h3FF, 10'd0, 10'd2, 10'd0, 10'd1};

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [DELAY_W-1:0]   i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic [FUNC_W-1:0]    i_func        = '0;
    logic [REG_W-1:0]     i_dest_reg    = '0;
    logic [REG_W-1:0]     i_src_a_reg   = '0;
    logic [REG_W-1:0]     i_src_b_reg   = '0;
    logic [ADDR_W-1:0]    i_mem_address = '0;
    logic                 i_out_stall   = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [CYC_W-1:0]     o_stall_cycles;
    logic [CNT_W-1:0]     o_issue_cycle;
    logic [KIND_W-1:0]    o_access_kind;
    logic [CYC_W-1:0]     o_access_cycles;
    logic [CNT_W-1:0]     o_row_updates;

    int                fail_count;
    int                pending;
    int                checked;
    int                conflicts;
    int                stalled;
    int                n_sent;
    int                idle_cycles;
    bit                gaps_on = 1'b1;
    bit                held_off;
    logic [ADDR_W-1:0] last_addr = '0;

    dram_row_buffer_timing_scoreboard_core u_top (.*);

    drbts_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_dest_reg     (i_dest_reg),
        .i_src_a_reg    (i_src_a_reg),
        .i_src_b_reg    (i_src_b_reg),
        .i_mem_address  (i_mem_address),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_stall_cycles (o_stall_cycles),
        .i_issue_cycle  (o_issue_cycle),
        .i_access_kind  (o_access_kind),
        .i_access_cycles(o_access_cycles),
        .i_row_updates  (o_row_updates),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_conflicts    (conflicts),
        .o_stalled      (stalled)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_item instr(input logic [FUNC_W-1:0] f, input logic [REG_W-1:0] d,
                                    input logic [REG_W-1:0] a, input logic [REG_W-1:0] b,
                                    input logic [ADDR_W-1:0] addr);
        t_item it;
        it.func        = f;
        it.dest_reg    = d;
        it.src_a_reg   = a;
        it.src_b_reg   = b;
        it.mem_address = addr;
        return it;
    endfunction

    // favor a few registers so dependences on the pending access are common
    function automatic logic [REG_W-1:0] pick_reg();
        if ($urandom_range(9) < 6) begin
            return REG_W'($urandom_range(3));
        end
        return REG_W'($urandom_range((1 << REG_W) - 1));
    endfunction

    function automatic t_item random_instr();
        t_item it;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            it.func = FUNC_ADD;
        end else if (pick < 45) begin
            it.func = FUNC_ADDI;
        end else if (pick < 65) begin
            it.func = FUNC_LOAD;
        end else if (pick < 85) begin
            it.func = FUNC_STORE;
        end else begin
            it.func = FUNC_W'($urandom_range(FUNC_UNDEF_HI, FUNC_OTHER));
        end
        it.dest_reg  = pick_reg();
        it.src_a_reg = pick_reg();
        it.src_b_reg = pick_reg();
        pick = $urandom_range(99);
        // stay in the last row half the time to get row hits
        if (pick < 50) begin
            it.mem_address = {last_addr[ADDR_W-1:ROW_LSB], ROW_LSB'($urandom)};
        end else if (pick < 55) begin
            it.mem_address = '1;
        end else if (pick < 60) begin
            it.mem_address = '0;
        end else begin
            it.mem_address = ADDR_W'($urandom);
        end
        if (it.func == FUNC_LOAD || it.func == FUNC_STORE) begin
            last_addr = it.mem_address;
        end
        return it;
    endfunction

    task automatic send_instr(input t_item it);
        while (gaps_on && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= it.func;
        i_dest_reg    <= it.dest_reg;
        i_src_a_reg   <= it.src_a_reg;
        i_src_b_reg   <= it.src_b_reg;
        i_mem_address <= it.mem_address;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // receiver: sparse random stalls, plus one long hold-off to back the block up
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held_off && n_sent >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= gaps_on && ($urandom_range(99) < 7);
        end
    end

    initial begin
        wait (i_rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset delays: row 10, column 2
        send_instr(instr(FUNC_ADD, 5'd0, 5'd0, 5'd0, 20'h00000));
        send_instr(instr(FUNC_OTHER, 5'd31, 5'd31, 5'd31, 20'hFFFFF));
        send_instr(instr(FUNC_LOAD, 5'd5, 5'd0, 5'd0, 20'h00000));
        send_instr(instr(FUNC_ADD, 5'd1, 5'd2, 5'd3, 20'h12345));
        send_instr(instr(FUNC_ADDI, 5'd6, 5'd5, 5'd0, 20'h00000));
        send_instr(instr(FUNC_LOAD, 5'd7, 5'd0, 5'd0, 20'h003FF));
        send_instr(instr(FUNC_ADD, 5'd8, 5'd9, 5'd10, 20'h00000));
        send_instr(instr(FUNC_ADD, 5'd1, 5'd2, 5'd7, 20'h00000));
        send_instr(instr(FUNC_STORE, 5'd9, 5'd0, 5'd0, 20'hFFFFF));
        // sources match the store's register, but only the destination matters here
        send_instr(instr(FUNC_ADD, 5'd1, 5'd9, 5'd9, 20'h00000));
        send_instr(instr(FUNC_ADDI, 5'd9, 5'd0, 5'd0, 20'h00000));
        send_instr(instr(FUNC_STORE, 5'd11, 5'd0, 5'd0, 20'hFFC00));
        send_instr(instr(FUNC_ADD, 5'd2, 5'd11, 5'd0, 20'h00000));
        send_instr(instr(FUNC_STORE, 5'd31, 5'd0, 5'd0, 20'h00400));
        send_instr(instr(FUNC_OTHER, 5'd0, 5'd0, 5'd0, 20'h00000));
        send_instr(instr(FUNC_LOAD, 5'd0, 5'd0, 5'd0, 20'h00800));
        send_instr(instr(FUNC_LOAD, 5'd0, 5'd0, 5'd0, 20'h00800));
        for (int f = FUNC_UNDEF_LO; f <= FUNC_UNDEF_HI; f++) begin
            send_instr(instr(FUNC_W'(f), 5'd0, 5'd0, 5'd0, 20'h00000));
        end
        send_instr(instr(FUNC_ADDI, 5'd31, 5'd31, 5'd31, 20'hFFFFF));
        send_instr(instr(FUNC_LOAD, 5'd0, 5'd0, 5'd0, 20'h00000));
        send_instr(instr(FUNC_ADD, 5'd3, 5'd4, 5'd0, 20'h00000));

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            if (p == RANDOM_PHASE) begin
                write_reg(CFG_ROW_DELAY, DELAY_W'($urandom));
                write_reg(CFG_COL_DELAY, DELAY_W'($urandom));
            end else begin
                write_reg(CFG_ROW_DELAY, ROW_SET[p]);
                write_reg(CFG_COL_DELAY, COL_SET[p]);
            end
            i_cfg_we <= 1'b0;
            gaps_on = (p != QUIET_PHASE);
            repeat (PHASE_ITEMS) send_instr(random_instr());
        end
        drain();

        $display("Covered %0d instructions over %0d delay settings,", n_sent, N_PHASES + 1);
        $display("with random gaps and a %0d-cycle output hold-off.", HOLD_OFF_CYCLES);
        $display("Checked %0d results: %0d row conflicts, %0d dependence stalls, %0d mismatches.",
                 checked, conflicts, stalled, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
